// ----- rtl/cgtl_pkg.sv -----
// shared types and constants for the context graph transition lookup unit
// no dependencies; imported by cgtl_graph_mem, the top level and the testbench
`timescale 1ns / 1ps

package cgtl_pkg;

    localparam int NUM_STATES      = 1024;
    localparam int NUM_TRANSITIONS = 4096;
    localparam int SYMBOL_BITS     = 16;

    // field widths fixed by the ports
    localparam int STATE_W  = 10;
    localparam int FIRST_W  = 12;
    localparam int COUNT_W  = 13;
    localparam int SLOT_W   = 12;
    localparam int SYMIN_W  = 16;
    localparam int WEIGHT_W = 24;

    localparam int STATE_AW = $clog2(NUM_STATES);
    localparam int TRANS_AW = $clog2(NUM_TRANSITIONS);
    localparam int CNT_W    = $clog2(NUM_TRANSITIONS + 1);

    typedef enum logic [1:0] {
        REQ_WRITE_STATE = 2'd0,
        REQ_WRITE_TRANS = 2'd1,
        REQ_QUERY       = 2'd2
    } req_type_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STATE,
        ST_SCAN,
        ST_EMIT
    } lookup_state_t;

    typedef struct packed {
        logic [FIRST_W-1:0] first;
        logic [COUNT_W-1:0] count;
    } state_entry_t;

    typedef struct packed {
        logic [SYMBOL_BITS-1:0]  sym;
        logic [WEIGHT_W-1:0]     weight;
        logic [STATE_W-1:0]      target;
        logic                    returns;
    } trans_entry_t;

    typedef struct packed {
        logic                en;
        logic [STATE_AW-1:0] addr;
        state_entry_t        data;
    } state_wr_t;

    typedef struct packed {
        logic                en;
        logic [TRANS_AW-1:0] addr;
        trans_entry_t        data;
    } trans_wr_t;

    typedef struct packed {
        logic                en;
        logic [STATE_AW-1:0] addr;
    } state_rd_t;

    typedef struct packed {
        logic                en;
        logic [TRANS_AW-1:0] addr;
    } trans_rd_t;

endpackage

// ----- rtl/cgtl_graph_mem.sv -----
// state table and transition memory, one write and one registered read port each
// depends on cgtl_pkg
`timescale 1ns / 1ps

module cgtl_graph_mem (
    input  logic                   clk,
    input  cgtl_pkg::state_wr_t    st_wr,
    input  cgtl_pkg::state_rd_t    st_rd,
    output cgtl_pkg::state_entry_t st_rd_data,
    input  cgtl_pkg::trans_wr_t    tr_wr,
    input  cgtl_pkg::trans_rd_t    tr_rd,
    output cgtl_pkg::trans_entry_t tr_rd_data
);

    import cgtl_pkg::*;

    state_entry_t state_mem [NUM_STATES];
    trans_entry_t trans_mem [NUM_TRANSITIONS];

    state_entry_t st_rd_data_reg;
    trans_entry_t tr_rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (st_wr.en)
        begin
            state_mem[st_wr.addr] <= st_wr.data;
        end
        if (st_rd.en)
        begin
            st_rd_data_reg <= state_mem[st_rd.addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (tr_wr.en)
        begin
            trans_mem[tr_wr.addr] <= tr_wr.data;
        end
        if (tr_rd.en)
        begin
            tr_rd_data_reg <= trans_mem[tr_rd.addr];
        end
    end

    assign st_rd_data = st_rd_data_reg;
    assign tr_rd_data = tr_rd_data_reg;

endmodule

// ----- rtl/context_graph_transition_lookup_unit.sv -----
// transition lookup over a compiled biasing graph held in two on-chip memories
// timing: writes finish in the accept cycle; a query reads the state entry, then scans k transitions
// (k = transitions scanned, 0 for a state with none), one transition memory read per cycle, and
// then waits to load the output register; a write word is taken every cycle, but only while idle
// reset: clears the controller, the output valid and start_state; memories are not cleared
// depends on cgtl_pkg and cgtl_graph_mem
`timescale 1ns / 1ps

module context_graph_transition_lookup_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                start_state_wen,
    input  logic [cgtl_pkg::STATE_W-1:0]        start_state,
    // request channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          req_type,
    input  logic [cgtl_pkg::STATE_W-1:0]        state_index,
    input  logic [cgtl_pkg::FIRST_W-1:0]        first_transition,
    input  logic [cgtl_pkg::COUNT_W-1:0]        transition_count,
    input  logic [cgtl_pkg::SLOT_W-1:0]         transition_slot,
    input  logic [cgtl_pkg::SYMIN_W-1:0]        symbol,
    input  logic signed [cgtl_pkg::WEIGHT_W-1:0] weight,
    input  logic [cgtl_pkg::STATE_W-1:0]        target_state,
    input  logic                                target_returns,
    // result channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [cgtl_pkg::STATE_W-1:0]        next_state,
    output logic signed [cgtl_pkg::WEIGHT_W-1:0] score,
    output logic                                matched
);

    import cgtl_pkg::*;

    // controller state
    lookup_state_t fsm_reg, fsm_next;
    logic [STATE_W-1:0] start_state_reg;
    logic               out_valid_reg, out_valid_next;

    // query context, no reset needed
    logic [SYMBOL_BITS-1:0] qsym_reg, qsym_next;
    logic                   oob_reg, oob_next;
    logic [TRANS_AW-1:0]    ptr_reg, ptr_next;
    logic [CNT_W-1:0]       remain_reg, remain_next;
    logic [WEIGHT_W-1:0]    eps_reg, eps_next;

    // finished result waiting for the output register
    logic [STATE_W-1:0]  res_state_reg, res_state_next;
    logic [WEIGHT_W-1:0] res_score_reg, res_score_next;
    logic                res_matched_reg, res_matched_next;

    // output word register
    logic [STATE_W-1:0]  out_state_reg;
    logic [WEIGHT_W-1:0] out_score_reg;
    logic                out_matched_reg;
    logic                out_load;

    // memory ports
    state_wr_t    st_wr;
    state_rd_t    st_rd;
    state_entry_t st_rd_data;
    trans_wr_t    tr_wr;
    trans_rd_t    tr_rd;
    trans_entry_t tr_rd_data;

    // scan helpers
    logic [CNT_W-1:0]    clamped_count;
    logic [TRANS_AW-1:0] ptr_wrap;
    logic [WEIGHT_W-1:0] eps_seen;
    logic                out_free;

    cgtl_graph_mem u_mem (
        .clk        (clk),
        .st_wr      (st_wr),
        .st_rd      (st_rd),
        .st_rd_data (st_rd_data),
        .tr_wr      (tr_wr),
        .tr_rd      (tr_rd),
        .tr_rd_data (tr_rd_data)
    );

    // counts beyond the memory depth scan every slot once
    always_comb
    begin
        if (oob_reg)
        begin
            clamped_count = '0;
        end
        else if (32'(st_rd_data.count) > NUM_TRANSITIONS)
        begin
            clamped_count = CNT_W'(NUM_TRANSITIONS);
        end
        else
        begin
            clamped_count = CNT_W'(st_rd_data.count);
        end
    end

    // slots wrap around the end of the transition memory
    assign ptr_wrap = (32'(ptr_reg) == NUM_TRANSITIONS - 1) ? '0 : ptr_reg + 1'b1;

    // last epsilon weight including the slot now on the read port
    assign eps_seen = (tr_rd_data.sym == '0) ? tr_rd_data.weight : eps_reg;

    // the output register can take a word now or at this edge
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        fsm_next         = fsm_reg;
        qsym_next        = qsym_reg;
        oob_next         = oob_reg;
        ptr_next         = ptr_reg;
        remain_next      = remain_reg;
        eps_next         = eps_reg;
        res_state_next   = res_state_reg;
        res_score_next   = res_score_reg;
        res_matched_next = res_matched_reg;
        out_load         = 1'b0;
        in_ready         = 1'b0;

        st_wr.en          = 1'b0;
        st_wr.addr        = STATE_AW'(state_index);
        st_wr.data.first  = first_transition;
        st_wr.data.count  = transition_count;
        st_rd.en          = 1'b0;
        st_rd.addr        = STATE_AW'(state_index);

        tr_wr.en           = 1'b0;
        tr_wr.addr         = TRANS_AW'(transition_slot);
        tr_wr.data.sym     = SYMBOL_BITS'(symbol);
        tr_wr.data.weight  = weight;
        tr_wr.data.target  = target_state;
        tr_wr.data.returns = target_returns;
        tr_rd.en           = 1'b0;
        tr_rd.addr         = ptr_reg;

        unique case (fsm_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    unique case (req_type)
                        REQ_WRITE_STATE:
                        begin
                            st_wr.en = (32'(state_index) < NUM_STATES);
                        end
                        REQ_WRITE_TRANS:
                        begin
                            tr_wr.en = (32'(transition_slot) < NUM_TRANSITIONS);
                        end
                        REQ_QUERY:
                        begin
                            st_rd.en  = 1'b1;
                            qsym_next = SYMBOL_BITS'(symbol);
                            oob_next  = (32'(state_index) >= NUM_STATES);
                            fsm_next  = ST_STATE;
                        end
                        default:
                        begin
                            // unused request code, dropped
                        end
                    endcase
                end
            end
            ST_STATE:
            begin
                // state entry is on the read port
                eps_next = '0;
                if (clamped_count == '0)
                begin
                    res_state_next   = start_state_reg;
                    res_score_next   = '0;
                    res_matched_next = 1'b0;
                    fsm_next         = ST_EMIT;
                end
                else
                begin
                    ptr_next    = TRANS_AW'(st_rd_data.first);
                    remain_next = clamped_count;
                    tr_rd.en    = 1'b1;
                    tr_rd.addr  = TRANS_AW'(st_rd_data.first);
                    fsm_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (tr_rd_data.sym == qsym_reg)
                begin
                    // first match ends the scan
                    res_state_next   = tr_rd_data.returns ? start_state_reg
                                                          : tr_rd_data.target;
                    res_score_next   = tr_rd_data.weight;
                    res_matched_next = 1'b1;
                    fsm_next         = ST_EMIT;
                end
                else if (remain_reg == CNT_W'(1))
                begin
                    // no match: start state with the last epsilon weight
                    res_state_next   = start_state_reg;
                    res_score_next   = eps_seen;
                    res_matched_next = 1'b0;
                    fsm_next         = ST_EMIT;
                end
                else
                begin
                    eps_next    = eps_seen;
                    ptr_next    = ptr_wrap;
                    remain_next = remain_reg - 1'b1;
                    tr_rd.en    = 1'b1;
                    tr_rd.addr  = ptr_wrap;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    fsm_next = ST_IDLE;
                end
            end
            default:
            begin
                fsm_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg         <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            start_state_reg <= '0;
        end
        else
        begin
            fsm_reg       <= fsm_next;
            out_valid_reg <= out_valid_next;
            if (start_state_wen)
            begin
                start_state_reg <= start_state;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        qsym_reg        <= qsym_next;
        oob_reg         <= oob_next;
        ptr_reg         <= ptr_next;
        remain_reg      <= remain_next;
        eps_reg         <= eps_next;
        res_state_reg   <= res_state_next;
        res_score_reg   <= res_score_next;
        res_matched_reg <= res_matched_next;
        if (out_load)
        begin
            out_state_reg   <= res_state_reg;
            out_score_reg   <= res_score_reg;
            out_matched_reg <= res_matched_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign next_state = out_state_reg;
    assign score      = out_score_reg;
    assign matched    = out_matched_reg;

    // a query always moves on to the state table read
    a_query_reads_state : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && req_type == REQ_QUERY) |=> (fsm_reg == ST_STATE))
        else $error("query accept did not start the state read");

    // writes finish in the accept cycle
    a_write_done : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && req_type != REQ_QUERY) |=> (fsm_reg == ST_IDLE))
        else $error("write left the controller busy");

    // the scan never runs with nothing left to read
    a_scan_remain : assert property (@(posedge clk) disable iff (!rst_n)
        (fsm_reg == ST_SCAN) |-> (remain_reg != '0))
        else $error("scan running with zero remaining transitions");

    // a result waiting with a free output register is shown next cycle
    a_emit_loads : assert property (@(posedge clk) disable iff (!rst_n)
        (fsm_reg == ST_EMIT && out_free) |=> (out_valid_reg && fsm_reg == ST_IDLE))
        else $error("pending result was not loaded");

    // a miss always lands on the start state
    a_miss_start : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_matched_reg) |-> (out_state_reg == start_state_reg))
        else $error("miss returned a state other than start");

endmodule

// ----- tb/sv/tb_context_graph_transition_lookup_unit.sv -----
// self-checking testbench for the context graph transition lookup unit
// keeps its own copy of the state table and transition memory, predicts every query
// depends on cgtl_pkg and context_graph_transition_lookup_unit
`timescale 1ns / 1ps

module tb_context_graph_transition_lookup_unit;
    import cgtl_pkg::*;

    // cycles with no accepted word before the run is declared hung; the slowest legal
    // query scans at most NUM_TRANSITIONS (4096) slots, plus receiver stalls
    localparam int WATCHDOG_LIMIT = 20000;
    // a write finishes in its accept cycle, so a short pause covers any tail work
    localparam int DRAIN_CYCLES   = 8;
    // mismatch lines printed before going quiet (all of them are still counted)
    localparam int REPORT_LINES   = 40;
    // the one request code the package leaves unnamed; the block drops it
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int MAX_COUNT_FIELD = (1 << COUNT_W) - 1;

    // one request word, every field as the block sees it
    typedef struct {
        logic [1:0]                 kind;
        logic [STATE_W-1:0]         state_idx;
        logic [FIRST_W-1:0]         first;
        logic [COUNT_W-1:0]         count;
        logic [SLOT_W-1:0]          slot;
        logic [SYMIN_W-1:0]         sym;
        logic [WEIGHT_W-1:0]        w;
        logic [STATE_W-1:0]         target;
        logic                       ret;
    } request_t;

    // one result word of a query
    typedef struct packed {
        logic [STATE_W-1:0]  next_state;
        logic [WEIGHT_W-1:0] score;
        logic                matched;
    } lookup_result_t;

    logic                       clk;
    logic                       rst_n;
    logic                       start_state_wen;
    logic [STATE_W-1:0]         start_state;
    logic                       in_valid;
    logic                       in_ready;
    logic [1:0]                 req_type;
    logic [STATE_W-1:0]         state_index;
    logic [FIRST_W-1:0]         first_transition;
    logic [COUNT_W-1:0]         transition_count;
    logic [SLOT_W-1:0]          transition_slot;
    logic [SYMIN_W-1:0]         symbol;
    logic signed [WEIGHT_W-1:0] weight;
    logic [STATE_W-1:0]         target_state;
    logic                       target_returns;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [STATE_W-1:0]         next_state;
    logic signed [WEIGHT_W-1:0] score;
    logic                       matched;

    // shadow of the graph held in the block, plus which entries were ever written
    state_entry_t       graph_states [NUM_STATES];
    trans_entry_t       graph_arcs   [NUM_TRANSITIONS];
    bit                 state_written [NUM_STATES];
    bit                 slot_written  [NUM_TRANSITIONS];
    logic [STATE_W-1:0] known_states [$];
    logic [SLOT_W-1:0]  known_slots  [$];
    logic [STATE_W-1:0] start_state_shadow;

    // query results still owed by the block, oldest first
    lookup_result_t     pending_lookups [$];

    int                 mismatch_count = 0;
    int                 idle_cycles    = 0;
    int                 send_gap_pct   = 0;
    int                 recv_stall_pct = 0;

    context_graph_transition_lookup_unit u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start_state_wen  (start_state_wen),
        .start_state      (start_state),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .req_type         (req_type),
        .state_index      (state_index),
        .first_transition (first_transition),
        .transition_count (transition_count),
        .transition_slot  (transition_slot),
        .symbol           (symbol),
        .weight           (weight),
        .target_state     (target_state),
        .target_returns   (target_returns),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .next_state       (next_state),
        .score            (score),
        .matched          (matched)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ---------------------------------------------------------------------------------
    // prediction
    // ---------------------------------------------------------------------------------

    // scan the queried state's arcs in slot order; the first symbol hit wins, otherwise
    // fall back to start with the weight of the last epsilon arc passed over
    function automatic lookup_result_t predict_lookup(input logic [STATE_W-1:0] s,
                                                      input logic [SYMIN_W-1:0] sym);
        lookup_result_t     res;
        logic [WEIGHT_W-1:0] eps_weight;
        trans_entry_t       arc;
        int unsigned        span;
        int unsigned        i;
        eps_weight     = '0;
        res.next_state = start_state_shadow;
        res.score      = '0;
        res.matched    = 1'b0;
        span = 32'(graph_states[s].count);
        if (span > NUM_TRANSITIONS)
            span = NUM_TRANSITIONS;
        i = 0;
        while (!res.matched && i < span)
        begin
            arc = graph_arcs[TRANS_AW'((graph_states[s].first + i) % NUM_TRANSITIONS)];
            if (arc.sym == sym[SYMBOL_BITS-1:0])
            begin
                res.matched    = 1'b1;
                res.score      = arc.weight;
                res.next_state = arc.returns ? start_state_shadow : arc.target;
            end
            else if (arc.sym == '0)
                eps_weight = arc.weight;
            i++;
        end
        if (!res.matched)
            res.score = eps_weight;
        return res;
    endfunction

    // true when a query of this symbol only ever reads entries that were written
    function automatic bit scan_is_safe(input logic [STATE_W-1:0] s,
                                        input logic [SYMIN_W-1:0] sym);
        int unsigned span;
        int unsigned i;
        int unsigned slot;
        bit          safe;
        bit          done;
        safe = state_written[s];
        done = !safe;
        span = 32'(graph_states[s].count);
        if (span > NUM_TRANSITIONS)
            span = NUM_TRANSITIONS;
        i = 0;
        while (!done && i < span)
        begin
            slot = (graph_states[s].first + i) % NUM_TRANSITIONS;
            if (!slot_written[TRANS_AW'(slot)])
            begin
                safe = 1'b0;
                done = 1'b1;
            end
            else if (graph_arcs[TRANS_AW'(slot)].sym == sym[SYMBOL_BITS-1:0])
                done = 1'b1;
            i++;
        end
        return safe;
    endfunction

    // ---------------------------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------------------------

    // every field random, so bits that the request kind ignores still toggle
    function automatic request_t blank_request(input logic [1:0] kind);
        request_t r;
        r.kind      = kind;
        r.state_idx = STATE_W'($urandom);
        r.first     = FIRST_W'($urandom);
        r.count     = COUNT_W'($urandom);
        r.slot      = SLOT_W'($urandom);
        r.sym       = SYMIN_W'($urandom);
        r.w         = WEIGHT_W'($urandom);
        r.target    = STATE_W'($urandom);
        r.ret       = 1'($urandom);
        return r;
    endfunction

    // mostly a small shared alphabet so that states see repeats and epsilon arcs
    function automatic logic [SYMIN_W-1:0] random_arc_symbol();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 20)
            return '0;
        else if (roll < 70)
            return SYMIN_W'($urandom_range(1, 8));
        return SYMIN_W'($urandom);
    endfunction

    function automatic logic [WEIGHT_W-1:0] random_weight();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 3)
            return {1'b1, {(WEIGHT_W-1){1'b0}}};
        else if (roll < 6)
            return {1'b0, {(WEIGHT_W-1){1'b1}}};
        return WEIGHT_W'($urandom);
    endfunction

    // aim at a hit on 40 percent of picks; if the pick would read an unwritten slot, fall back
    // to the first arc's symbol, which always stops the scan on a written slot
    function automatic logic [SYMIN_W-1:0] choose_query_symbol(input logic [STATE_W-1:0] s);
        state_entry_t       ent;
        logic [SYMIN_W-1:0] sym;
        int unsigned        roll;
        int unsigned        span;
        ent  = graph_states[s];
        roll = $urandom_range(99);
        span = (ent.count > 8) ? 8 : 32'(ent.count);
        if (roll < 40 && span != 0)
            sym = graph_arcs[TRANS_AW'((ent.first + $urandom_range(span - 1))
                                       % NUM_TRANSITIONS)].sym;
        else if (roll < 55)
            sym = '0;
        else if (roll < 75)
            sym = SYMIN_W'($urandom_range(1, 8));
        else
            sym = SYMIN_W'($urandom);
        if (!scan_is_safe(s, sym))
            sym = graph_arcs[ent.first].sym;
        return sym;
    endfunction

    // present one word at the falling edge, hold it until accepted, then update the
    // shadow graph or queue the predicted result
    task automatic issue_request(input request_t r);
        @(negedge clk);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid         <= 1'b1;
        req_type         <= r.kind;
        state_index      <= r.state_idx;
        first_transition <= r.first;
        transition_count <= r.count;
        transition_slot  <= r.slot;
        symbol           <= r.sym;
        weight           <= r.w;
        target_state     <= r.target;
        target_returns   <= r.ret;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        case (r.kind)
            REQ_WRITE_STATE:
            begin
                graph_states[r.state_idx] = '{first: r.first, count: r.count};
                if (!state_written[r.state_idx])
                    known_states.push_back(r.state_idx);
                state_written[r.state_idx] = 1'b1;
            end
            REQ_WRITE_TRANS:
            begin
                graph_arcs[r.slot] = '{sym: r.sym[SYMBOL_BITS-1:0], weight: r.w,
                                       target: r.target, returns: r.ret};
                if (!slot_written[r.slot])
                    known_slots.push_back(r.slot);
                slot_written[r.slot] = 1'b1;
            end
            REQ_QUERY:
                pending_lookups.push_back(predict_lookup(r.state_idx, r.sym));
            default:
                ;
        endcase
    endtask

    task automatic send_state_entry(input logic [STATE_W-1:0] s, input logic [FIRST_W-1:0] first,
                                    input logic [COUNT_W-1:0] count);
        request_t r;
        r           = blank_request(REQ_WRITE_STATE);
        r.state_idx = s;
        r.first     = first;
        r.count     = count;
        issue_request(r);
    endtask

    task automatic send_arc(input logic [SLOT_W-1:0] slot, input logic [SYMIN_W-1:0] sym,
                            input logic [WEIGHT_W-1:0] w, input logic [STATE_W-1:0] target,
                            input logic ret);
        request_t r;
        r        = blank_request(REQ_WRITE_TRANS);
        r.slot   = slot;
        r.sym    = sym;
        r.w      = w;
        r.target = target;
        r.ret    = ret;
        issue_request(r);
    endtask

    task automatic send_query(input logic [STATE_W-1:0] s, input logic [SYMIN_W-1:0] sym);
        request_t r;
        r           = blank_request(REQ_QUERY);
        r.state_idx = s;
        r.sym       = sym;
        issue_request(r);
    endtask

    // drop valid and wait until every owed result is back and the block has settled
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_lookups.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    // the register is only touched while the block is idle
    task automatic write_start_state(input logic [STATE_W-1:0] value);
        wait_drained();
        @(negedge clk);
        start_state_wen    <= 1'b1;
        start_state        <= value;
        start_state_shadow  = value;
        @(negedge clk);
        start_state_wen    <= 1'b0;
    endtask

    // ---------------------------------------------------------------------------------
    // checking
    // ---------------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < REPORT_LINES)
            $display("%0t mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // outputs are sampled at the rising edge where the result word is taken
    always @(posedge clk)
    begin : check_results
        lookup_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_lookups.size() == 0)
                report_mismatch("result word with nothing owed", 32'(next_state), '0);
            else
            begin
                want = pending_lookups.pop_front();
                if (next_state !== want.next_state)
                    report_mismatch("next_state", 32'(next_state), 32'(want.next_state));
                if (score !== want.score)
                    report_mismatch("score", 32'($unsigned(score)), 32'(want.score));
                if (matched !== want.matched)
                    report_mismatch("matched", 32'(matched), 32'(want.matched));
            end
        end
    end

    // receiver stalls at random, driven on the falling edge
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // hang detector: any accepted word on either side restarts the count
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ---------------------------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------------------------

    // start_state must come out of reset as zero
    task automatic test_reset_start_state();
        send_state_entry(10'd2, FIRST_W'($urandom), '0);
        send_query(10'd2, SYMIN_W'($urandom));
    endtask

    // hand-built graph covering the corner cases
    task automatic test_directed_graph();
        write_start_state({STATE_W{1'b1}});
        // two epsilon arcs at the top of memory with extreme weights, then two arcs
        // that wrap round to slot zero
        send_arc(12'd4094, '0, {1'b1, {(WEIGHT_W-1){1'b0}}}, 10'd5, 1'b0);
        send_arc(12'd4095, '0, {1'b0, {(WEIGHT_W-1){1'b1}}}, {STATE_W{1'b1}}, 1'b1);
        send_arc(12'd0, {SYMIN_W{1'b1}}, 24'h001000, {STATE_W{1'b1}}, 1'b0);
        send_arc(12'd1, 16'd7, {WEIGHT_W{1'b1}}, '0, 1'b1);
        send_state_entry({STATE_W{1'b1}}, 12'd4094, 13'd4);
        send_state_entry('0, FIRST_W'($urandom), '0);
        // count far above the memory size, clamped; the scan still stops on a hit
        send_state_entry(10'd512, '0, COUNT_W'(MAX_COUNT_FIELD));
        send_state_entry(10'd1, '0, 13'd2);
        // exactly the memory size
        send_state_entry(10'd3, 12'd4095, 13'(NUM_TRANSITIONS));
        // unknown request kind, dropped by the block
        issue_request(blank_request(REQ_UNUSED));

        // hit after wrapping past the last slot
        send_query({STATE_W{1'b1}}, {SYMIN_W{1'b1}});
        // hit on a return-to-start arc
        send_query({STATE_W{1'b1}}, 16'd7);
        // epsilon query takes the first epsilon arc
        send_query({STATE_W{1'b1}}, '0);
        // miss: start state with the last epsilon weight seen
        send_query({STATE_W{1'b1}}, 16'd1234);
        // state with no arcs
        send_query('0, '0);
        send_query(10'd512, {SYMIN_W{1'b1}});
        send_query(10'd512, 16'd7);
        // miss with no epsilon arc on the way: score zero
        send_query(10'd1, 16'd99);
        send_query(10'd3, '0);
    endtask

    // random traffic: mostly small well-formed subgraphs followed by queries into them,
    // with stray writes and dropped request kinds mixed in
    task automatic test_random_graph(input int gap_pct, input int stall_pct,
                                     input logic [STATE_W-1:0] start_value,
                                     input int n_items);
        int                 sent;
        int                 roll;
        int                 n_arcs;
        int                 n_queries;
        int unsigned        first;
        int                 i;
        logic [STATE_W-1:0] s;
        logic [COUNT_W-1:0] cnt;
        write_start_state(start_value);
        send_gap_pct   = gap_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < n_items)
        begin
            roll = $urandom_range(99);
            if (roll < 55)
            begin
                // fresh subgraph, sometimes straddling the end of memory
                s      = STATE_W'($urandom_range(NUM_STATES - 1));
                n_arcs = ($urandom_range(6) == 0) ? 0 : int'($urandom_range(1, 6));
                first  = ($urandom_range(9) == 0) ? $urandom_range(NUM_TRANSITIONS - 6,
                                                                   NUM_TRANSITIONS - 1)
                                                  : $urandom_range(NUM_TRANSITIONS - 1);
                for (i = 0; i < n_arcs; i++)
                    send_arc(SLOT_W'((first + i) % NUM_TRANSITIONS), random_arc_symbol(),
                             random_weight(), STATE_W'($urandom_range(NUM_STATES - 1)),
                             1'($urandom_range(1)));
                cnt = COUNT_W'(n_arcs);
                if (n_arcs != 0 && $urandom_range(9) == 0)
                    cnt = COUNT_W'($urandom_range(NUM_TRANSITIONS, MAX_COUNT_FIELD));
                send_state_entry(s, FIRST_W'(first), cnt);
                n_queries = $urandom_range(1, 5);
                repeat (n_queries)
                    send_query(s, choose_query_symbol(s));
                sent += n_arcs + 1 + n_queries;
            end
            else if (roll < 75)
            begin
                // revisit any state built so far
                s = known_states[$urandom_range(known_states.size() - 1)];
                send_query(s, choose_query_symbol(s));
                sent++;
            end
            else if (roll < 85)
            begin
                // overwrite an arbitrary slot
                send_arc(SLOT_W'($urandom_range(NUM_TRANSITIONS - 1)), random_arc_symbol(),
                         random_weight(), STATE_W'($urandom_range(NUM_STATES - 1)),
                         1'($urandom_range(1)));
                sent++;
            end
            else if (roll < 93)
            begin
                // repoint a state; a non-empty entry always starts on a written slot
                s = STATE_W'($urandom_range(NUM_STATES - 1));
                if (known_slots.size() != 0 && $urandom_range(3) != 0)
                    send_state_entry(s, known_slots[$urandom_range(known_slots.size() - 1)],
                                     COUNT_W'($urandom_range(1, 8)));
                else
                    send_state_entry(s, FIRST_W'($urandom_range(NUM_TRANSITIONS - 1)), '0);
                sent++;
            end
            else
            begin
                issue_request(blank_request(REQ_UNUSED));
                sent++;
            end
        end
    endtask

    // ---------------------------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------------------------

    initial
    begin : main
        int idx;
        rst_n              = 1'b0;
        start_state_wen    = 1'b0;
        start_state        = '0;
        in_valid           = 1'b0;
        req_type           = '0;
        state_index        = '0;
        first_transition   = '0;
        transition_count   = '0;
        transition_slot    = '0;
        symbol             = '0;
        weight             = '0;
        target_state       = '0;
        target_returns     = 1'b0;
        start_state_shadow = '0;
        for (idx = 0; idx < NUM_STATES; idx++)
        begin
            graph_states[idx]  = '0;
            state_written[idx] = 1'b0;
        end
        for (idx = 0; idx < NUM_TRANSITIONS; idx++)
        begin
            graph_arcs[idx]   = '0;
            slot_written[idx] = 1'b0;
        end

        // sender gaps light, receiver stalls heavy for the first stretch
        send_gap_pct   = 16;
        recv_stall_pct = 52;

        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_start_state();
        test_directed_graph();
        test_random_graph(16, 52, '0, 500);
        test_random_graph(52, 16, {STATE_W{1'b1}}, 500);
        test_random_graph(0, 0, STATE_W'($urandom_range(1, NUM_STATES - 2)), 500);

        wait_drained();
        if (mismatch_count == 0 && pending_lookups.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
